@@ sv/seam_pkg.sv @@
package seam_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 12;

    localparam int TAB_LEN   = 1 << SINE_TABLE_BITS;
    localparam int STEP_BITS = 32;
    localparam int GAIN_BITS = 16;
    localparam int SINE_BITS = 15;
    localparam int PROD_BITS = GAIN_BITS + SINE_BITS;
    localparam int ENV_BITS  = 16;

    localparam int REG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = STEP_BITS;

    localparam int MID_DEPTH     = 2;
    localparam int MID_PTR_BITS  = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
    localparam int MID_CNT_BITS  = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH     = 2;
    localparam int OUT_PTR_BITS  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

    localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = STEP_BITS'(858993);
    localparam logic [GAIN_BITS-1:0] ENV_MEAN_RESET   = GAIN_BITS'(18022);
    localparam logic [GAIN_BITS-1:0] ENV_SWING_RESET  = GAIN_BITS'(14746);

    localparam logic [ENV_BITS-1:0]    ENV_ONE    = ENV_BITS'(32768);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // series divisors 6, 20, 42, ... as rounded-up reciprocals, exact for terms below 2^33
    localparam int     SERIES_SHIFT = 41;
    localparam longint SERIES_ONE   = longint'(1) <<< SERIES_SHIFT;
    localparam longint SERIES_RECIP [1:7] = '{
        (SERIES_ONE + 5) / 6,
        (SERIES_ONE + 19) / 20,
        (SERIES_ONE + 41) / 42,
        (SERIES_ONE + 71) / 72,
        (SERIES_ONE + 109) / 110,
        (SERIES_ONE + 155) / 156,
        (SERIES_ONE + 209) / 210
    };

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_ENV_MEAN   = 2'd1,
        REG_ENV_SWING  = 2'd2
    } seam_reg_index_t;

    // one classified sample waiting for the back end
    typedef struct packed {
        logic [SAMPLE_BITS-1:0]     sample;
        logic                       neg;
        logic [SINE_TABLE_BITS-1:0] addr;
    } seam_item_t;

    // quarter-wave entry i: fixed-point Q30 series of sin at the bin midpoint
    function automatic logic [SINE_BITS-1:0] sine_entry(input int unsigned i);
        longint      x;
        longint      x2;
        longint      term;
        longint      sum;
        longint      v;
        logic [95:0] scaled;
        x = ((2 * longint'(i) + 1) * HALF_PI_Q30) >>> (SINE_TABLE_BITS + 1);
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x2) >>> 30;
            scaled = 96'(term) * 96'(SERIES_RECIP[k]);
            term = longint'(scaled >> SERIES_SHIFT);
            if (k[0] == 1'b1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum < 0)
            sum = 0;
        v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (v > 32767)
            v = 32767;
        return v[SINE_BITS-1:0];
    endfunction

endpackage

@@ sv/seam_front.sv @@
module seam_front
    import seam_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic [STEP_BITS-1:0] phase_step,
    output seam_item_t           item
);

    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [1:0]            quad;
    logic [SINE_TABLE_BITS-1:0] idx;

    // phase advances before the lookup, so the word uses the new phase
    assign phase_acc_next = phase_acc_reg + PHASE_BITS'(phase_step);
    assign quad = phase_acc_next[PHASE_BITS-1 -: 2];
    assign idx  = phase_acc_next[PHASE_BITS-3 -: SINE_TABLE_BITS];

    always_comb
    begin
        item.sample = sample_in;
        item.neg    = quad[1];
        // odd quadrants run the table backwards
        item.addr   = quad[0] ? ~idx : idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_acc_reg <= '0;
        else if (accept)
            phase_acc_reg <= phase_acc_next;
    end

endmodule

@@ sv/seam_queue.sv @@
module seam_queue
    import seam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  seam_item_t push_item,
    output logic       full,
    input  logic       pop,
    output seam_item_t pop_item,
    output logic       empty
);

    seam_item_t              data_reg [MID_DEPTH];
    logic [MID_PTR_BITS-1:0] wr_ptr_reg;
    logic [MID_PTR_BITS-1:0] rd_ptr_reg;
    logic [MID_CNT_BITS-1:0] count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full     = (count_reg == MID_CNT_BITS'(MID_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = data_reg[rd_ptr_reg];

    function automatic logic [MID_PTR_BITS-1:0] ptr_inc(input logic [MID_PTR_BITS-1:0] p);
        return (p == MID_PTR_BITS'(MID_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ sv/seam_sine_rom.sv @@
module seam_sine_rom
    import seam_pkg::*;
(
    input  logic                       clk,
    input  logic [SINE_TABLE_BITS-1:0] addr,
    output logic [SINE_BITS-1:0]       data
);

    logic [SINE_BITS-1:0] rom_w [TAB_LEN];
    logic [SINE_BITS-1:0] data_reg;

    for (genvar g = 0; g < TAB_LEN; g++)
    begin : g_entry
        assign rom_w[g] = sine_entry(g);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;

endmodule

@@ sv/seam_back.sv @@
module seam_back
    import seam_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  seam_item_t             q_item,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  logic [GAIN_BITS-1:0]   env_mean,
    input  logic [GAIN_BITS-1:0]   env_swing,
    output logic                   empty,
    input  logic                   pop,
    output logic [SAMPLE_BITS-1:0] sample_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_ENV   = 4'b0100,
        S_MUL   = 4'b1000
    } seam_state_t;

    seam_state_t state_reg;
    seam_state_t state_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   neg_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [ENV_BITS-1:0]    env_reg;
    logic [SINE_BITS-1:0]   rom_data;

    logic [PROD_BITS:0]              prod_up;
    logic [PROD_BITS-15:0]           swing_mag;
    logic signed [GAIN_BITS+2:0]     env_s;
    logic [ENV_BITS-1:0]             env_next;
    logic [SAMPLE_BITS+ENV_BITS-1:0] y_full;
    logic [SAMPLE_BITS:0]            y_sh;
    logic [SAMPLE_BITS-1:0]          y_sat;

    logic [SAMPLE_BITS-1:0]  out_data_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] out_wr_reg;
    logic [OUT_PTR_BITS-1:0] out_rd_reg;
    logic [OUT_CNT_BITS-1:0] out_count_reg;
    logic                    out_full;
    logic                    out_push;
    logic                    out_pop;

    seam_sine_rom u_rom (
        .clk  (clk),
        .addr (q_item.addr),
        .data (rom_data)
    );

    assign out_full = (out_count_reg == OUT_CNT_BITS'(OUT_DEPTH));
    assign empty    = (out_count_reg == '0);
    assign out_pop  = pop && !empty;
    assign out_push = (state_reg == S_MUL);
    assign sample_out = out_data_reg[out_rd_reg];

    // one word in flight, so a free slot at start is still free at the end
    assign q_pop = (state_reg == S_IDLE) && !q_empty && !out_full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (q_pop) state_next = S_LOOK;
            S_LOOK:  state_next = S_ENV;
            S_ENV:   state_next = S_MUL;
            S_MUL:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // negative swing rounds toward minus infinity
    always_comb
    begin
        prod_up   = {1'b0, prod_reg} + (PROD_BITS + 1)'(32767);
        swing_mag = neg_reg ? prod_up[PROD_BITS:15] : {1'b0, prod_reg[PROD_BITS-1:15]};
        if (neg_reg)
            env_s = $signed({3'b000, env_mean}) - $signed({2'b00, swing_mag});
        else
            env_s = $signed({3'b000, env_mean}) + $signed({2'b00, swing_mag});
        if (env_s < 0)
            env_next = '0;
        else if (env_s > $signed({3'b000, ENV_ONE}))
            env_next = ENV_ONE;
        else
            env_next = env_s[ENV_BITS-1:0];
    end

    always_comb
    begin
        y_full = {{ENV_BITS{1'b0}}, sample_reg} * {{SAMPLE_BITS{1'b0}}, env_reg};
        y_sh   = y_full[SAMPLE_BITS+15:15];
        y_sat  = y_sh[SAMPLE_BITS] ? SAMPLE_MAX : y_sh[SAMPLE_BITS-1:0];
    end

    function automatic logic [OUT_PTR_BITS-1:0] ptr_inc(input logic [OUT_PTR_BITS-1:0] p);
        return (p == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sample_reg <= q_item.sample;
            neg_reg    <= q_item.neg;
        end
        if (state_reg == S_LOOK)
            prod_reg <= {{SINE_BITS{1'b0}}, env_swing} * {{GAIN_BITS{1'b0}}, rom_data};
        if (state_reg == S_ENV)
            env_reg <= env_next;
        if (out_push)
            out_data_reg[out_wr_reg] <= y_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_push)
                out_wr_reg <= ptr_inc(out_wr_reg);
            if (out_pop)
                out_rd_reg <= ptr_inc(out_rd_reg);
            if (out_push && !out_pop)
                out_count_reg <= out_count_reg + 1'b1;
            else if (out_pop && !out_push)
                out_count_reg <= out_count_reg - 1'b1;
        end
    end

    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= OUT_CNT_BITS'(OUT_DEPTH))
        else $error("result buffer overrun");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_LOOK)
        else $error("dequeued word did not start the sequence");

    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ENV |=> env_reg <= ENV_ONE)
        else $error("envelope out of range");

    a_word_lands: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |=> !empty)
        else $error("finished word not buffered");

endmodule

@@ sv/sine_envelope_amplitude_modulator.sv @@
// Sine envelope amplitude modulator: each pushed 12-bit sample first advances a
// 32-bit phase accumulator by phase_step (a fraction of a turn, wrapping), then
// is scaled by the envelope env_mean + env_swing * sin(phase), both
// unsigned Q1.15 and clamped to 0..1.0; the result is (sample * env) >> 15,
// clamped to 4095. The back end handles one word at a time (table read,
// gain multiply, envelope clamp, sample multiply) and takes the next word
// from the queue only after the last one has been written to the result
// buffer. A two-word queue between the phase front end and the back end and
// a two-word result buffer let input and output stall independently. Registers
// are written through wr_en/wr_index/wr_data (0 phase_step, 1 env_mean,
// 2 env_swing; other indexes are ignored) and must only be changed while
// no words are in flight.
module sine_envelope_amplitude_modulator
    import seam_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [SAMPLE_BITS-1:0]    sample_in,
    output logic                      empty,
    input  logic                      pop,
    output logic [SAMPLE_BITS-1:0]    sample_out,
    input  logic                      wr_en,
    input  logic [REG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data
);

    logic [STEP_BITS-1:0] phase_step_reg;
    logic [GAIN_BITS-1:0] env_mean_reg;
    logic [GAIN_BITS-1:0] env_swing_reg;

    logic       accept;
    seam_item_t front_item;
    seam_item_t q_item;
    logic       q_empty;
    logic       q_pop;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RESET;
            env_mean_reg   <= ENV_MEAN_RESET;
            env_swing_reg  <= ENV_SWING_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PHASE_STEP: phase_step_reg <= wr_data[STEP_BITS-1:0];
                REG_ENV_MEAN:   env_mean_reg   <= wr_data[GAIN_BITS-1:0];
                REG_ENV_SWING:  env_swing_reg  <= wr_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    seam_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .sample_in  (sample_in),
        .phase_step (phase_step_reg),
        .item       (front_item)
    );

    seam_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    seam_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_item     (q_item),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .env_mean   (env_mean_reg),
        .env_swing  (env_swing_reg),
        .empty      (empty),
        .pop        (pop),
        .sample_out (sample_out)
    );

endmodule
